// ----- rtl/core/iat_pkg.sv -----
// ----------------------------------------------------------------------------
// iat_pkg: shared types and constants for the insertable array table
// Command and status codes, table sizes, result struct, word conversions.
// ----------------------------------------------------------------------------
`default_nettype none

package iat_pkg;

	// table geometry
	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;

	// fixed field widths on the stream ports
	localparam int CMD_W      = 3;
	localparam int POS_W      = 4;
	localparam int DATA_W     = 32;
	localparam int ECOUNT_W   = 5;
	localparam int STATUS_W   = 2;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 40;

	// derived widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_READ   = 3'd3,
		CMD_WRITE  = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// one result item
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  count;
		status_t           status;
	} res_t;

	// memory port requests from the sequencer
	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [WORD_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

	// input word -> stored word (low bits, zero fill when wider)
	function automatic logic [WORD_WIDTH-1:0] to_word(input logic [DATA_W-1:0] w);
		logic [WORD_WIDTH+DATA_W-1:0] t;
		t = {{WORD_WIDTH{1'b0}}, w};
		return t[WORD_WIDTH-1:0];
	endfunction

	// stored word -> read data, sign-extended then cut to the port width
	function automatic logic [DATA_W-1:0] to_data(input logic [WORD_WIDTH-1:0] w);
		logic [WORD_WIDTH+DATA_W-1:0] t;
		t = {{DATA_W{w[WORD_WIDTH-1]}}, w};
		return t[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/insertable_array_table_top.sv -----
// ----------------------------------------------------------------------------
// insertable_array_table_top: ordered table of signed words with insert/delete
// Holds up to DEPTH (16) signed 32-bit words in order plus a count of entries
// in use. Each input transfer carries one command (append, insert, delete,
// read, write, clear) and yields exactly one output transfer with the read
// data (zero unless a successful read), the count after the command and a
// status (ok, full, index out of range); a rejected command changes nothing.
// The entries live in one simple dual-port RAM, so shifting moves one entry
// per cycle. Insert below the end and delete below the last entry shift the
// entries above the position, and a read waits for the registered RAM data.
// A new command is taken while the previous result still waits in the output
// register. There is no clearing pass after reset; entries beyond the count
// are never read back.
// ----------------------------------------------------------------------------
`default_nettype none

module insertable_array_table_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	// [2:0] cmd, [6:3] position, [38:7] word_in, [39] zero
	input  wire logic [iat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [31:0] read_data, [36:32] entry_count, [38:37] status, [39] zero
	output      logic [iat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	import iat_pkg::*;

	// input field unpacking
	logic [CMD_W-1:0]  in_cmd;
	logic [POS_W-1:0]  in_pos;
	logic [DATA_W-1:0] in_word;

	assign in_cmd  = s_axis_tdata[CMD_W-1:0];
	assign in_pos  = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
	assign in_word = s_axis_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];

	// sequencer <-> RAM
	mem_req_t              mem_req;
	logic [WORD_WIDTH-1:0] mem_rdata;

	// sequencer -> output register
	logic res_valid;
	res_t res;
	logic out_free;

	// output register
	logic             out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [ECOUNT_W-1:0] out_count_q;
	status_t          out_status_q;

	assign out_free = !out_valid_q || m_axis_tready;

	iat_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (in_cmd),
		.position  (in_pos),
		.word_in   (in_word),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	iat_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// the sequencer only issues a result when the register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q   <= res.read_data;
			out_count_q  <= ECOUNT_W'(res.count);
			out_status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-ECOUNT_W-STATUS_W){1'b0}},
		out_status_q, out_count_q, out_data_q};

endmodule

`default_nettype wire

// ----- rtl/core/iat_ram.sv -----
// ----------------------------------------------------------------------------
// iat_ram: simple dual-port RAM
// One write port, one read port, registered read data held when not read.
// ----------------------------------------------------------------------------
`default_nettype none

module iat_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
	input  wire logic [WIDTH_P-1:0]                            wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
	output      logic [WIDTH_P-1:0]                            rdata
);

	logic [WIDTH_P-1:0] mem_q [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/iat_seq.sv -----
// ----------------------------------------------------------------------------
// iat_seq: command sequencer
// Decodes one command, checks range and fill, walks the RAM for shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module iat_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [iat_pkg::CMD_W-1:0]     cmd,
	input  wire logic [iat_pkg::POS_W-1:0]     position,
	input  wire logic [iat_pkg::DATA_W-1:0]    word_in,
	input  wire logic                          out_free,
	output      logic                          res_valid,
	output      iat_pkg::res_t                 res,
	output      iat_pkg::mem_req_t             mem_req,
	input  wire logic [iat_pkg::WORD_WIDTH-1:0] mem_rdata
);

	import iat_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_UP     = 6'b001000,
		S_INSFIN = 6'b010000,
		S_DN     = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [IDX_W-1:0]      rd_addr_q, rd_addr_d;

	logic [CMP_W-1:0] pos_c, cnt_c;
	logic             full, in_rng, ins_rng, at_last;
	logic [IDX_W-1:0] pos_idx, cnt_idx, last_idx;

	assign in_ready = (state_q == S_IDLE);

	assign pos_c    = CMP_W'(pos_q);
	assign cnt_c    = CMP_W'(count_q);
	assign full     = (cnt_c == CMP_W'(DEPTH));
	assign in_rng   = (pos_c < cnt_c);
	assign ins_rng  = (pos_c <= cnt_c);
	assign at_last  = ((pos_c + CMP_W'(1)) == cnt_c);
	assign pos_idx  = pos_c[IDX_W-1:0];
	assign cnt_idx  = count_q[IDX_W-1:0];
	assign last_idx = cnt_idx - IDX_W'(1);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		rd_addr_d     = rd_addr_q;
		mem_req       = '0;
		res_valid     = 1'b0;
		res.read_data = '0;
		res.status    = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_APPEND: begin
						if (out_free) begin
							if (full) begin
								res.status = ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = cnt_idx;
								mem_req.wdata = word_q;
								count_d       = count_q + CNT_W'(1);
							end
							res_valid = 1'b1;
							state_d   = S_IDLE;
						end
					end
					CMD_INSERT: begin
						if (!ins_rng || full || pos_c == cnt_c) begin
							if (out_free) begin
								if (!ins_rng) begin
									res.status = ST_RANGE;
								end else if (full) begin
									res.status = ST_FULL;
								end else begin
									mem_req.we    = 1'b1;
									mem_req.waddr = pos_idx;
									mem_req.wdata = word_q;
									count_d       = count_q + CNT_W'(1);
								end
								res_valid = 1'b1;
								state_d   = S_IDLE;
							end
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = last_idx;
							rd_addr_d     = last_idx;
							state_d       = S_UP;
						end
					end
					CMD_DELETE: begin
						if (!in_rng || at_last) begin
							if (out_free) begin
								if (!in_rng) begin
									res.status = ST_RANGE;
								end else begin
									count_d = count_q - CNT_W'(1);
								end
								res_valid = 1'b1;
								state_d   = S_IDLE;
							end
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = pos_idx + IDX_W'(1);
							rd_addr_d     = pos_idx + IDX_W'(1);
							state_d       = S_DN;
						end
					end
					CMD_READ: begin
						if (!in_rng) begin
							if (out_free) begin
								res.status = ST_RANGE;
								res_valid  = 1'b1;
								state_d    = S_IDLE;
							end
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = pos_idx;
							state_d       = S_RDWAIT;
						end
					end
					CMD_WRITE: begin
						if (out_free) begin
							if (!in_rng) begin
								res.status = ST_RANGE;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = pos_idx;
								mem_req.wdata = word_q;
							end
							res_valid = 1'b1;
							state_d   = S_IDLE;
						end
					end
					CMD_CLEAR: begin
						if (out_free) begin
							count_d   = '0;
							res_valid = 1'b1;
							state_d   = S_IDLE;
						end
					end
					default: begin
						// unused codes: no effect, ok
						if (out_free) begin
							res_valid = 1'b1;
							state_d   = S_IDLE;
						end
					end
				endcase
			end
			S_RDWAIT: begin
				// read data holds while no new read is issued
				if (out_free) begin
					res.read_data = to_data(mem_rdata);
					res_valid     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_UP: begin
				// move entry up, fetch the one below it
				mem_req.we    = 1'b1;
				mem_req.waddr = rd_addr_q + IDX_W'(1);
				mem_req.wdata = mem_rdata;
				if (rd_addr_q == pos_idx) begin
					state_d = S_INSFIN;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_addr_q - IDX_W'(1);
					rd_addr_d     = rd_addr_q - IDX_W'(1);
				end
			end
			S_INSFIN: begin
				if (out_free) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_idx;
					mem_req.wdata = word_q;
					count_d       = count_q + CNT_W'(1);
					res_valid     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DN: begin
				// move entry down, fetch the one above it
				if (rd_addr_q == last_idx) begin
					if (out_free) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = rd_addr_q - IDX_W'(1);
						mem_req.wdata = mem_rdata;
						count_d       = count_q - CNT_W'(1);
						res_valid     = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = rd_addr_q - IDX_W'(1);
					mem_req.wdata = mem_rdata;
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_addr_q + IDX_W'(1);
					rd_addr_d     = rd_addr_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr_d;
		if (in_valid && in_ready) begin
			cmd_q  <= cmd_t'(cmd);
			pos_q  <= position;
			word_q <= to_word(word_in);
		end
	end

	// count never runs past capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// read and write never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("read and write to the same entry");

	// a result only goes out into a free output register
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued with output register busy");

	// count only moves when a result is issued
	a_count_on_res: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |=> $stable(count_q))
		else $error("entry count changed without a result");

	// the table is only changed after an accepted command
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_req.we)
		else $error("memory write while idle");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for insertable_array_table_top
// Drives command transfers (append, insert, delete, read, write, clear and the
// spare codes) into the table and checks every result transfer against a
// hand-written result or a behavioral copy of the table kept in the bench. A short directed table comes
// first, then constrained-by-hand random traffic with random stalls on both
// streams, a long output hold-off and a full drain in the middle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import iat_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int RANDOM_ITEMS   = 900;
	localparam int WATCHDOG_LIMIT = 2000;  // idle cycles
	localparam int SINK_HOLD      = 120;   // long output hold-off, in cycles
	localparam int END_TAIL       = 40;    // quiet cycles after the last result

	// unused command codes, the block must ignore them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

	// result field offsets in m_axis_tdata
	localparam int COUNT_LSB  = DATA_W;
	localparam int STATUS_LSB = DATA_W + ECOUNT_W;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  idx;
		logic [DATA_W-1:0] word;
		int                reps;   // >1: repeated with random words
		bit                typed;  // want holds a hand-written result
		res_t              want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// bench copy of the table
	logic [DATA_W-1:0] shadow_words [DEPTH];
	int                shadow_fill;
	int                peak_fill;

	res_t results_due [$];

	int  fail_count;
	int  results_seen;
	int  n_ok, n_full, n_range, n_read_hits;
	int  commands_sent;
	int  sender_gap_max;
	bit  sink_choke;  // sender asks the receiver for one long hold-off

	insertable_array_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	// Applies one command to the shadow table and returns the result it yields.
	// Index test comes before the full test on insert; rejected commands change
	// nothing; spare codes fall through untouched.
	function automatic res_t table_apply(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] idx, input logic [DATA_W-1:0] word);
		res_t r;
		int   k;
		r.read_data = '0;
		r.status    = ST_OK;
		case (op)
			CMD_APPEND: begin
				if (shadow_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_words[shadow_fill] = word;
					shadow_fill++;
				end
			end
			CMD_INSERT: begin
				if (idx > shadow_fill) begin
					r.status = ST_RANGE;
				end else if (shadow_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = shadow_fill; k > idx; k--)
						shadow_words[k] = shadow_words[k-1];
					shadow_words[idx] = word;
					shadow_fill++;
				end
			end
			CMD_DELETE: begin
				if (idx >= shadow_fill) begin
					r.status = ST_RANGE;
				end else begin
					for (k = idx; k + 1 < shadow_fill; k++)
						shadow_words[k] = shadow_words[k+1];
					shadow_fill--;
				end
			end
			CMD_READ: begin
				if (idx >= shadow_fill)
					r.status = ST_RANGE;
				else
					r.read_data = shadow_words[idx];
			end
			CMD_WRITE: begin
				if (idx >= shadow_fill)
					r.status = ST_RANGE;
				else
					shadow_words[idx] = word;
			end
			CMD_CLEAR: begin
				shadow_fill = 0;
			end
			default: ;
		endcase
		r.count = CNT_W'(shadow_fill);
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
		return r;
	endfunction

	function automatic plan_row_t plan_step(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] idx, input logic [DATA_W-1:0] word, input int reps,
			input bit typed, input logic [DATA_W-1:0] data, input int cnt,
			input status_t st);
		plan_row_t p;
		p.op             = op;
		p.idx            = idx;
		p.word           = word;
		p.reps           = reps;
		p.typed          = typed;
		p.want.read_data = data;
		p.want.count     = CNT_W'(cnt);
		p.want.status    = st;
		return p;
	endfunction

	// One command transfer: hold valid until accepted, then queue the result
	// it must produce and idle for a random number of cycles.
	task automatic issue(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] idx,
			input logic [DATA_W-1:0] word, input bit typed, input res_t typed_res);
		res_t model_res;
		int   gap;
		s_axis_tdata  <= {{(IN_TDATA_W-CMD_W-POS_W-DATA_W){1'b0}}, word, idx, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		model_res = table_apply(op, idx, word);
		results_due.push_back(typed ? typed_res : model_res);
		commands_sent++;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender stops and waits until every queued result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_due.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Sender: reset, directed table, random traffic, end of run.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t         plan [$];
		plan_row_t         p;
		res_t              none;
		logic [CMD_W-1:0]  op;
		logic [POS_W-1:0]  idx;
		logic [DATA_W-1:0] word;
		mix_t              mix;
		int                r, w_app, w_ins, w_del, real_items, burst_left, top;

		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		shadow_fill    = 0;
		peak_fill      = 0;
		fail_count     = 0;
		commands_sent  = 0;
		sender_gap_max = 11;
		sink_choke     = 0;
		none           = '0;
		foreach (shadow_words[k])
			shadow_words[k] = '0;

		// Directed table. Rows with a typed result check the obvious cases;
		// the rest fall back to the shadow table.
		// empty table: everything indexed is out of range
		plan.push_back(plan_step(CMD_READ,   4'd0, '0, 1, 1, '0, 0, ST_RANGE));
		plan.push_back(plan_step(CMD_INSERT, 4'd1, '0, 1, 1, '0, 0, ST_RANGE));
		// word extremes, insert at the front and at the end
		plan.push_back(plan_step(CMD_APPEND, 4'd0, WORD_MAX, 1, 1, '0, 1, ST_OK));
		plan.push_back(plan_step(CMD_APPEND, 4'd9, WORD_MIN, 1, 1, '0, 2, ST_OK));
		plan.push_back(plan_step(CMD_INSERT, 4'd0, WORD_ONES, 1, 1, '0, 3, ST_OK));
		plan.push_back(plan_step(CMD_INSERT, 4'd3, '0, 1, 1, '0, 4, ST_OK));
		plan.push_back(plan_step(CMD_READ,   4'd0, '0, 1, 1, WORD_ONES, 4, ST_OK));
		plan.push_back(plan_step(CMD_WRITE,  4'd3, 32'h5A5A_A5A5, 1, 1, '0, 4, ST_OK));
		// delete exactly at the count is one past the end
		plan.push_back(plan_step(CMD_DELETE, 4'd4, '0, 1, 1, '0, 4, ST_RANGE));
		// fill up, then hit the full cases
		plan.push_back(plan_step(CMD_APPEND, 4'd0, '0, DEPTH - 4, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_APPEND, 4'd0, WORD_ONES, 1, 1, '0, DEPTH, ST_FULL));
		plan.push_back(plan_step(CMD_INSERT, 4'd15, '0, 1, 1, '0, DEPTH, ST_FULL));
		// shift the whole table down, drop the last, re-insert at the end
		plan.push_back(plan_step(CMD_DELETE, 4'd0, '0, 1, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_DELETE, 4'd14, '0, 1, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_INSERT, 4'd14, WORD_MIN, 1, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_READ,   4'd2, '0, 1, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_SPARE_HI, 4'd15, WORD_ONES, 1, 0, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_CLEAR,  4'd5, WORD_ONES, 1, 1, '0, 0, ST_OK));
		plan.push_back(plan_step(CMD_WRITE,  4'd0, WORD_MAX, 1, 1, '0, 0, ST_RANGE));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			p = plan[i];
			for (int n = 0; n < p.reps; n++)
				issue(p.op, p.idx, (p.reps > 1) ? $urandom : p.word, p.typed, p.want);
		end
		drain_results();

		// Random traffic. The mix drifts between growing, shrinking and even so
		// the table spends time empty, full and in between; most positions
		// land on live entries, one in ten anywhere.
		mix        = MIX_GROW;
		real_items = 0;
		burst_left = 0;
		while (real_items < RANDOM_ITEMS) begin
			if (real_items % 40 == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0: sender_gap_max = 0;
					1: sender_gap_max = 3;
					default: sender_gap_max = 11;
				endcase
			end
			// back-to-back offers while the receiver holds off
			if (real_items == 300) begin
				sink_choke = 1;
				burst_left = 40;
			end
			if (burst_left > 0) begin
				sender_gap_max = 0;
				burst_left--;
			end
			if (real_items == 600)
				drain_results();

			case (mix)
				MIX_GROW: begin
					w_app = 30; w_ins = 30; w_del = 8;
				end
				MIX_SHRINK: begin
					w_app = 8; w_ins = 10; w_del = 45;
				end
				default: begin
					w_app = 18; w_ins = 18; w_del = 18;
				end
			endcase
			r = $urandom_range(0, 99);
			if (r < w_app)
				op = CMD_APPEND;
			else if (r < w_app + w_ins)
				op = CMD_INSERT;
			else if (r < w_app + w_ins + w_del)
				op = CMD_DELETE;
			else if (r >= 98)
				op = (r == 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
			else if (r >= 96)
				op = CMD_CLEAR;
			else if (r % 2 == 1)
				op = CMD_READ;
			else
				op = CMD_WRITE;

			if ($urandom_range(0, 9) == 0) begin
				idx = POS_W'($urandom_range(0, DEPTH - 1));
			end else if (op == CMD_INSERT) begin
				top = (shadow_fill < DEPTH) ? shadow_fill : DEPTH - 1;
				idx = POS_W'($urandom_range(0, top));
			end else begin
				top = (shadow_fill > 0) ? shadow_fill - 1 : 0;
				idx = POS_W'($urandom_range(0, top));
			end

			case ($urandom_range(0, 7))
				0: word = WORD_MIN;
				1: word = WORD_MAX;
				2: word = '0;
				3: word = WORD_ONES;
				default: word = $urandom;
			endcase

			issue(op, idx, word, 0, none);
			if (op != CMD_SPARE_LO && op != CMD_SPARE_HI)
				real_items++;
		end

		drain_results();
		repeat (END_TAIL) @(posedge clk);

		$display("run summary: %0d commands, %0d results; ok %0d, full %0d, out of range %0d",
			commands_sent, results_seen, n_ok, n_full, n_range);
		$display("run summary: peak fill %0d of %0d, %0d reads returned data, %0d mismatches",
			peak_fill, DEPTH, n_read_hits, fail_count);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls per result, stall depth re-drawn every 50
	// results, plus one long hold-off when the sender asks for it.
	// ------------------------------------------------------------------------
	initial begin : sink_pacing
		int stall_max;
		int stall;
		int taken;
		m_axis_tready <= 1'b0;
		stall_max = 11;
		taken     = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (taken % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_max = 0;
					1: stall_max = 3;
					default: stall_max = 11;
				endcase
			end
			stall = $urandom_range(0, stall_max);
			if (sink_choke) begin
				sink_choke = 0;
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			taken++;
		end
	end

	// ------------------------------------------------------------------------
	// Result check: each output transfer against the oldest queued result.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		res_t              want;
		logic [DATA_W-1:0] got_data;
		logic [CNT_W-1:0]  got_count;
		logic [STATUS_W-1:0] got_status;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_data   = m_axis_tdata[DATA_W-1:0];
			got_count  = m_axis_tdata[COUNT_LSB +: ECOUNT_W];
			got_status = m_axis_tdata[STATUS_LSB +: STATUS_W];
			results_seen++;
			case (got_status)
				ST_OK:    n_ok++;
				ST_FULL:  n_full++;
				default:  n_range++;
			endcase
			if (results_due.size() == 0) begin
				fail_count++;
				$display("%0t: result transfer expected none pending, got %h",
					$time, m_axis_tdata);
			end else begin
				want = results_due.pop_front();
				if (want.status == ST_OK && want.read_data != '0)
					n_read_hits++;
				if (got_data !== want.read_data) begin
					fail_count++;
					$display("%0t: read_data expected %h, got %h",
						$time, want.read_data, got_data);
				end
				if (got_count !== want.count) begin
					fail_count++;
					$display("%0t: entry_count expected %0d, got %0d",
						$time, want.count, got_count);
				end
				if (got_status !== want.status) begin
					fail_count++;
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, got_status);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too many cycles without a transfer on either stream.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results pending",
					$time, idle_cycles, results_due.size());
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/core/iat_pkg.sv
rtl/core/iat_ram.sv
rtl/core/iat_seq.sv
rtl/core/insertable_array_table_top.sv
tb/sv/tb_top.sv
